### rtl/ppic_pkg.sv
package ppic_pkg;

  // Fixed widths of the register file
  localparam int unsigned GAIN_W    = 16;
  localparam int unsigned LIMIT_W   = 16;
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned INTEG_W   = LIMIT_W + 1;
  localparam int unsigned CFG_IDX_W = 3;

  // Defaults for the top level parameters
  localparam int unsigned DEF_SAMPLE_WIDTH   = 16;
  localparam int unsigned DEF_GAIN_FRAC_BITS = 8;
  localparam int unsigned DEF_OUT_WIDTH      = 24;

  // Control modes; the unused code behaves as off
  typedef enum logic [MODE_W-1:0] {
    MODE_OFF = 2'd0,
    MODE_POS = 2'd1,
    MODE_INC = 2'd2
  } ppic_mode_e;

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE      = 3'd0,
    CFG_TARGET    = 3'd1,
    CFG_GAIN_P    = 3'd2,
    CFG_GAIN_I    = 3'd3,
    CFG_GAIN_D    = 3'd4,
    CFG_DEAD_ZONE = 3'd5,
    CFG_INT_LIMIT = 3'd6,
    CFG_MAX_OUT   = 3'd7
  } ppic_cfg_idx_e;

  // Fixed-width settings handed from the register file to the datapath
  typedef struct packed {
    logic [MODE_W-1:0]         mode;
    logic signed [GAIN_W-1:0]  gain_p;
    logic signed [GAIN_W-1:0]  gain_i;
    logic signed [GAIN_W-1:0]  gain_d;
    logic [LIMIT_W-1:0]        dead_zone;
    logic [LIMIT_W-1:0]        integral_limit;
    logic [LIMIT_W-1:0]        max_output;
  } ppic_cfg_t;

endpackage

### rtl/ppic_cfg_regs.sv
module ppic_cfg_regs
  import ppic_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
  parameter int unsigned CFG_W        = (SAMPLE_WIDTH > GAIN_W) ? SAMPLE_WIDTH : GAIN_W
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [CFG_IDX_W-1:0]           cfg_index_i,
  input  logic [CFG_W-1:0]               cfg_data_i,
  output ppic_cfg_t                      cfg_o,
  output logic signed [SAMPLE_WIDTH-1:0] target_o
);

  ppic_cfg_t                      cfg_q;
  logic signed [SAMPLE_WIDTH-1:0] target_q;

  // Write one register per enabled cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q    <= '0;
      target_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_MODE:      cfg_q.mode           <= cfg_data_i[MODE_W-1:0];
        CFG_TARGET:    target_q             <= $signed(cfg_data_i[SAMPLE_WIDTH-1:0]);
        CFG_GAIN_P:    cfg_q.gain_p         <= $signed(cfg_data_i[GAIN_W-1:0]);
        CFG_GAIN_I:    cfg_q.gain_i         <= $signed(cfg_data_i[GAIN_W-1:0]);
        CFG_GAIN_D:    cfg_q.gain_d         <= $signed(cfg_data_i[GAIN_W-1:0]);
        CFG_DEAD_ZONE: cfg_q.dead_zone      <= cfg_data_i[LIMIT_W-1:0];
        CFG_INT_LIMIT: cfg_q.integral_limit <= cfg_data_i[LIMIT_W-1:0];
        CFG_MAX_OUT:   cfg_q.max_output     <= cfg_data_i[LIMIT_W-1:0];
        default:       cfg_q                <= cfg_q;
      endcase
    end
  end

  assign cfg_o    = cfg_q;
  assign target_o = target_q;

endmodule

### rtl/ppic_core.sv
module ppic_core
  import ppic_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH   = DEF_SAMPLE_WIDTH,
  parameter int unsigned GAIN_FRAC_BITS = DEF_GAIN_FRAC_BITS,
  parameter int unsigned OUT_WIDTH      = DEF_OUT_WIDTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           step_i,
  input  logic signed [SAMPLE_WIDTH-1:0] measure_i,
  input  ppic_cfg_t                      cfg_i,
  input  logic signed [SAMPLE_WIDTH-1:0] target_i,
  output logic signed [OUT_WIDTH-1:0]    drive_o,
  output logic                           in_dead_zone_o
);

  localparam int unsigned EW   = SAMPLE_WIDTH + 1;
  localparam int unsigned D1W  = SAMPLE_WIDTH + 2;
  localparam int unsigned D2W  = SAMPLE_WIDTH + 3;
  localparam int unsigned MAGW = (EW > LIMIT_W) ? EW : LIMIT_W;
  localparam int unsigned PW   = GAIN_W + D2W;
  localparam int unsigned SUMW = ((PW > OUT_WIDTH) ? PW : OUT_WIDTH) + 3;

  localparam logic signed [SUMW-1:0] OutMax =
    {{(SUMW - OUT_WIDTH + 1){1'b0}}, {(OUT_WIDTH - 1){1'b1}}};
  localparam logic signed [SUMW-1:0] OutMin = ~OutMax;

  // Error history and accumulators
  logic signed [EW-1:0]        err_last_q,  err_last_d;
  logic signed [EW-1:0]        err_last2_q, err_last2_d;
  logic signed [INTEG_W-1:0]   integ_q,     integ_d;
  logic signed [OUT_WIDTH-1:0] out_acc_q,   out_acc_d;

  logic signed [EW-1:0]        err;
  logic [EW-1:0]               err_mag;
  logic                        dz;
  logic                        is_pos;
  logic                        is_inc;
  logic signed [D1W-1:0]       diff1;
  logic signed [D2W-1:0]       diff2;
  logic signed [D2W-1:0]       op_p;
  logic signed [D2W-1:0]       op_d;
  logic signed [PW-1:0]        prod_p;
  logic signed [PW-1:0]        prod_i;
  logic signed [PW-1:0]        prod_d;
  logic signed [SUMW-1:0]      term_p;
  logic signed [SUMW-1:0]      term_i;
  logic signed [SUMW-1:0]      term_d;
  logic signed [SUMW-1:0]      int_lim;
  logic signed [SUMW-1:0]      out_lim;
  logic signed [SUMW-1:0]      integ_sum;
  logic signed [SUMW-1:0]      integ_clamp;
  logic signed [SUMW-1:0]      pos_sum;
  logic signed [SUMW-1:0]      pos_sat;
  logic signed [SUMW-1:0]      inc_sum;
  logic signed [SUMW-1:0]      inc_clamp;

  // Mode decode; the unused code acts as off
  always_comb begin
    is_pos = 1'b0;
    is_inc = 1'b0;
    unique case (cfg_i.mode)
      MODE_POS: is_pos = 1'b1;
      MODE_INC: is_inc = 1'b1;
      default:  is_pos = 1'b0;
    endcase
  end

  // Error, its magnitude against the dead zone, and its differences
  assign err     = EW'(target_i) - EW'(measure_i);
  assign err_mag = err[EW-1] ? EW'(-err) : EW'(err);
  assign dz      = MAGW'(err_mag) <= MAGW'(cfg_i.dead_zone);
  assign diff1   = D1W'(err) - D1W'(err_last_q);
  assign diff2   = D2W'(err) - (D2W'(err_last_q) <<< 1) + D2W'(err_last2_q);

  // Pick the multiplier operands for the mode
  assign op_p = is_pos ? D2W'(err)   : D2W'(diff1);
  assign op_d = is_pos ? D2W'(diff1) : diff2;

  // Three gain products, scaled down by the gain fraction
  assign prod_p = $signed(cfg_i.gain_p) * op_p;
  assign prod_i = $signed(cfg_i.gain_i) * D2W'(err);
  assign prod_d = $signed(cfg_i.gain_d) * op_d;
  assign term_p = SUMW'(prod_p >>> GAIN_FRAC_BITS);
  assign term_i = SUMW'(prod_i >>> GAIN_FRAC_BITS);
  assign term_d = SUMW'(prod_d >>> GAIN_FRAC_BITS);

  assign int_lim = $signed(SUMW'(cfg_i.integral_limit));
  assign out_lim = $signed(SUMW'(cfg_i.max_output));

  // Positional: clamp the integral, then saturate the sum to the output range
  always_comb begin
    integ_sum = SUMW'(integ_q) + term_i;
    priority if (integ_sum > int_lim) begin
      integ_clamp = int_lim;
    end else if (integ_sum < -int_lim) begin
      integ_clamp = -int_lim;
    end else begin
      integ_clamp = integ_sum;
    end
    pos_sum = term_p + integ_clamp + term_d;
    priority if (pos_sum > OutMax) begin
      pos_sat = OutMax;
    end else if (pos_sum < OutMin) begin
      pos_sat = OutMin;
    end else begin
      pos_sat = pos_sum;
    end
  end

  // Incremental: add the increments to the running output and clamp
  always_comb begin
    inc_sum = SUMW'(out_acc_q) + term_p + term_i + term_d;
    priority if (inc_sum > out_lim) begin
      inc_clamp = out_lim;
    end else if (inc_sum < -out_lim) begin
      inc_clamp = -out_lim;
    end else begin
      inc_clamp = inc_sum;
    end
  end

  // Result and next state
  always_comb begin
    err_last_d     = err_last_q;
    err_last2_d    = err_last2_q;
    integ_d        = integ_q;
    out_acc_d      = out_acc_q;
    drive_o        = '0;
    in_dead_zone_o = 1'b0;
    if (is_pos || is_inc) begin
      err_last_d     = err;
      err_last2_d    = err_last_q;
      in_dead_zone_o = dz;
      if (dz) begin
        integ_d   = '0;
        out_acc_d = '0;
      end else if (is_pos) begin
        integ_d   = integ_clamp[INTEG_W-1:0];
        out_acc_d = pos_sat[OUT_WIDTH-1:0];
        drive_o   = pos_sat[OUT_WIDTH-1:0];
      end else begin
        out_acc_d = inc_clamp[OUT_WIDTH-1:0];
        drive_o   = inc_clamp[OUT_WIDTH-1:0];
      end
    end
  end

  // Advance the state once per word taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_last_q  <= '0;
      err_last2_q <= '0;
      integ_q     <= '0;
      out_acc_q   <= '0;
    end else if (step_i) begin
      err_last_q  <= err_last_d;
      err_last2_q <= err_last2_d;
      integ_q     <= integ_d;
      out_acc_q   <= out_acc_d;
    end
  end

endmodule

### rtl/pid_position_incremental_controller.sv
// PID controller, positional or incremental, one measurement word per control tick.
// Input channel: in_valid_i / in_stall_o carry measure_i. Output channel:
// out_valid_o / out_stall_i carry drive_o and in_dead_zone_o. A word moves at a
// clock edge where valid is high and stall is low. Configuration is a plain
// write port (cfg_we_i, cfg_index_i, cfg_data_i), to be written only while the block
// is idle; the block itself does not enforce this. A measurement waits in the
// input register until the result register is free; the single-pass datapath
// runs from the input register straight into the result register. Throughput:
// one word per cycle while the receiver does not stall, set by the single-pass
// datapath with its three gain multipliers feeding the accumulator update.
// Reset clears the configuration, the error history and both accumulators; no
// word is held afterwards. When the receiver stalls, the result register
// holds its word, the input register fills, and then in_stall_o rises, so no
// word is lost or repeated.
module pid_position_incremental_controller
  import ppic_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH   = DEF_SAMPLE_WIDTH,
  parameter int unsigned GAIN_FRAC_BITS = DEF_GAIN_FRAC_BITS,
  parameter int unsigned OUT_WIDTH      = DEF_OUT_WIDTH,
  parameter int unsigned CFG_W          = (SAMPLE_WIDTH > GAIN_W) ? SAMPLE_WIDTH : GAIN_W
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [SAMPLE_WIDTH-1:0] measure_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [OUT_WIDTH-1:0]    drive_o,
  output logic                           in_dead_zone_o,
  input  logic                           cfg_we_i,
  input  logic [CFG_IDX_W-1:0]           cfg_index_i,
  input  logic [CFG_W-1:0]               cfg_data_i
);

  ppic_cfg_t                      cfg;
  logic signed [SAMPLE_WIDTH-1:0] target;

  logic                           in_valid_q;
  logic signed [SAMPLE_WIDTH-1:0] meas_q;
  logic                           out_valid_q;
  logic signed [OUT_WIDTH-1:0]    drive_q;
  logic                           dz_q;

  logic                           in_take;
  logic                           advance;
  logic                           step;
  logic signed [OUT_WIDTH-1:0]    drive_d;
  logic                           dz_d;

  ppic_cfg_regs #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .CFG_W        (CFG_W)
  ) u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg),
    .target_o    (target)
  );

  // Handshake: the input register moves on whenever the result register is free
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;
  assign step       = in_valid_q && advance;

  // Hold the taken measurement
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      meas_q <= measure_i;
    end
  end

  ppic_core #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
    .OUT_WIDTH      (OUT_WIDTH)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .measure_i      (meas_q),
    .cfg_i          (cfg),
    .target_i       (target),
    .drive_o        (drive_d),
    .in_dead_zone_o (dz_d)
  );

  // Result register: load on a step, drop once the word is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      drive_q <= drive_d;
      dz_q    <= dz_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign drive_o        = drive_q;
  assign in_dead_zone_o = dz_q;

  // A full input register behind a blocked result must stall the sender
  a_stall_when_full : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_q && out_stall_i |-> in_stall_o
  ) else $error("input not stalled while both stages are blocked");

  // A word in the dead zone always drives zero
  a_dead_zone_zero : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && dz_q |-> drive_q == '0
  ) else $error("non-zero drive inside dead zone");

  // With the controller off a result is all zero
  a_off_zero : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $past(step) && (cfg.mode != MODE_POS) && (cfg.mode != MODE_INC)
      |-> drive_q == '0 && !dz_q
  ) else $error("result not zero while controller is off");

  // A step always leaves a word in the result register
  a_step_loads : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_q
  ) else $error("result register empty after a step");

endmodule
